// ===== design/shell_command_lexer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the shell command lexer
// Clocked concurrent checks with asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef SHELL_COMMAND_LEXER_CORE_ASSERT_SVH
`define SHELL_COMMAND_LEXER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define SCL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer check failed");

// antecedent implies consequent in the next cycle
`define SCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer check failed");

`else

`define SCL_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SCL_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/scl_pkg.sv =====
// ----------------------------------------------------------------------------
// scl_pkg
// Types and constants shared by the shell command lexer modules.
// ----------------------------------------------------------------------------
package scl_pkg;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChSq    = 8'h27;
  localparam logic [7:0] ChDq    = 8'h22;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    KindWord = 3'd0,
    KindLt   = 3'd1,
    KindLtLt = 3'd2,
    KindGt   = 3'd3,
    KindGtGt = 3'd4,
    KindEol  = 3'd5
  } token_kind_e;

  typedef enum logic [1:0] {
    QuoteNone   = 2'd0,
    QuoteSingle = 2'd1,
    QuoteDouble = 2'd2
  } quote_mode_e;

  typedef enum logic [1:0] {
    HeldNone = 2'd0,
    HeldLt   = 2'd1,
    HeldGt   = 2'd2
  } held_bracket_e;

  // One queued step: an optional single operator flushed from the hold,
  // then an optional result that follows it.
  typedef struct packed {
    logic        a_valid;
    token_kind_e a_kind;
    logic        b_valid;
    token_kind_e b_kind;
    logic [7:0]  b_byte;
    logic        b_start;
    logic        b_last;
  } scl_entry_t;

  typedef struct packed {
    logic not_full;
    logic not_empty;
  } scl_q_status_t;

endpackage

// ===== design/scl_front.sv =====
// ----------------------------------------------------------------------------
// scl_front
// Accepts line bytes, tracks quote, word and bracket state, and builds one
// queue entry per input word that yields results.
// ----------------------------------------------------------------------------
module scl_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             char_in_i,
  input  logic                   line_end_i,
  input  scl_pkg::scl_q_status_t q_status_i,
  output logic                   push_o,
  output scl_pkg::scl_entry_t    entry_o
);
  import scl_pkg::*;

  quote_mode_e   quote_q, quote_d;
  held_bracket_e held_q, held_d;
  logic          in_word_q, in_word_d;
  logic          accept;
  logic          doubled;
  scl_entry_t    entry;

  assign in_ready_o = q_status_i.not_full;
  assign accept     = in_valid_i & in_ready_o;

  assign doubled = ((held_q == HeldLt) && (char_in_i == ChLt)) ||
                   ((held_q == HeldGt) && (char_in_i == ChGt));

  always_comb begin
    quote_d   = quote_q;
    held_d    = held_q;
    in_word_d = in_word_q;
    entry     = '0;
    entry.a_kind  = (held_q == HeldLt) ? KindLt : KindGt;
    entry.b_kind  = KindWord;
    if (line_end_i) begin
      entry.a_valid = (held_q != HeldNone);
      entry.b_valid = 1'b1;
      entry.b_kind  = KindEol;
      entry.b_last  = 1'b1;
      quote_d   = QuoteNone;
      held_d    = HeldNone;
      in_word_d = 1'b0;
    end else if (doubled) begin
      entry.b_valid = 1'b1;
      entry.b_kind  = (held_q == HeldLt) ? KindLtLt : KindGtGt;
      entry.b_start = 1'b1;
      held_d        = HeldNone;
    end else begin
      // flush a single bracket, then handle the byte itself
      entry.a_valid = (held_q != HeldNone);
      held_d        = HeldNone;
      if (quote_q != QuoteNone) begin
        entry.b_valid = 1'b1;
        entry.b_byte  = char_in_i;
        entry.b_start = ~in_word_q;
        in_word_d     = 1'b1;
        if (((quote_q == QuoteSingle) && (char_in_i == ChSq)) ||
            ((quote_q == QuoteDouble) && (char_in_i == ChDq))) begin
          quote_d = QuoteNone;
        end
      end else if (char_in_i == ChSpace) begin
        in_word_d = 1'b0;
      end else if (char_in_i == ChLt) begin
        in_word_d = 1'b0;
        held_d    = HeldLt;
      end else if (char_in_i == ChGt) begin
        in_word_d = 1'b0;
        held_d    = HeldGt;
      end else begin
        if (char_in_i == ChSq) begin
          quote_d = QuoteSingle;
        end else if (char_in_i == ChDq) begin
          quote_d = QuoteDouble;
        end
        entry.b_valid = 1'b1;
        entry.b_byte  = char_in_i;
        entry.b_start = ~in_word_q;
        in_word_d     = 1'b1;
      end
    end
  end

  assign entry_o = entry;
  assign push_o  = accept & (entry.a_valid | entry.b_valid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quote_q   <= QuoteNone;
      held_q    <= HeldNone;
      in_word_q <= 1'b0;
    end else if (accept) begin
      quote_q   <= quote_d;
      held_q    <= held_d;
      in_word_q <= in_word_d;
    end
  end

endmodule

// ===== design/scl_queue.sv =====
// ----------------------------------------------------------------------------
// scl_queue
// Short FIFO of step entries between the front and the back.
// ----------------------------------------------------------------------------
module scl_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  scl_pkg::scl_entry_t    push_entry_i,
  input  logic                   pop_i,
  output scl_pkg::scl_entry_t    head_o,
  output scl_pkg::scl_q_status_t status_o
);
  import scl_pkg::*;

  scl_entry_t           store_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 do_push, do_pop;

  assign status_o.not_full  = (count_q != QueueCntW'(QueueDepth));
  assign status_o.not_empty = (count_q != '0);
  assign do_push = push_i & status_o.not_full;
  assign do_pop  = pop_i & status_o.not_empty;
  assign head_o  = store_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/scl_back.sv =====
// ----------------------------------------------------------------------------
// scl_back
// Expands queued entries into one or two result words and holds each in
// the output register until it is taken.
// ----------------------------------------------------------------------------
module scl_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scl_pkg::scl_entry_t    head_i,
  input  scl_pkg::scl_q_status_t q_status_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output scl_pkg::token_kind_e   token_kind_o,
  output logic [7:0]             word_byte_o,
  output logic                   token_start_o,
  output logic                   last_o
);
  import scl_pkg::*;

  logic        valid_q;
  token_kind_e kind_q, kind_d;
  logic [7:0]  byte_q, byte_d;
  logic        start_q, start_d;
  logic        last_q, last_d;
  logic        phase_q, phase_d;
  logic        load;
  logic        take_a;

  assign load   = q_status_i.not_empty & (~valid_q | out_ready_i);
  assign take_a = head_i.a_valid & ~phase_q;

  always_comb begin
    phase_d = phase_q;
    pop_o   = 1'b0;
    if (take_a) begin
      kind_d  = head_i.a_kind;
      byte_d  = '0;
      start_d = 1'b1;
      last_d  = 1'b0;
    end else begin
      kind_d  = head_i.b_kind;
      byte_d  = head_i.b_byte;
      start_d = head_i.b_start;
      last_d  = head_i.b_last;
    end
    if (load) begin
      // advance to the second result, or retire the entry
      if (take_a && head_i.b_valid) begin
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        pop_o   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_d;
      byte_q  <= byte_d;
      start_q <= start_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign token_kind_o  = kind_q;
  assign word_byte_o   = byte_q;
  assign token_start_o = start_q;
  assign last_o        = last_q;

endmodule

// ===== design/shell_command_lexer_core.sv =====
// ----------------------------------------------------------------------------
// shell_command_lexer_core
// Quote-aware command-line lexer: words split at unquoted spaces, and the
// redirect operators <, <<, > and >> recognized greedily.
// ----------------------------------------------------------------------------
// The input port takes one line byte per cycle while tready is high, or an
// end-of-line word with tlast set. Each input word yields zero, one or two
// results; the front classifies the byte in the same cycle it is accepted and
// queues at most one entry (four deep) for the back, which drives one result
// per cycle on the output register while the output is taken. Throughput is
// therefore one input word per cycle as long as the results fit the output
// port's one-per-cycle limit: an input that yields two results (a single
// bracket followed by a word byte or an end of line) needs an extra output
// slot, which the queue absorbs before tready drops. Results pass through
// the queue and the output register. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "shell_command_lexer_core_assert.svh"

module shell_command_lexer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_in
  input  logic        s_axis_tlast_i,   // line_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] word_byte, [8] token_start
  output logic [2:0]  m_axis_tuser_o,   // [2:0] token_kind
  output logic        m_axis_tlast_o    // last
);
  import scl_pkg::*;

  scl_q_status_t q_status;
  scl_entry_t    push_entry, head;
  logic          push, pop;
  token_kind_e   kind;
  logic [7:0]    word_byte;
  logic          token_start;

  scl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .char_in_i  (s_axis_tdata_i),
    .line_end_i (s_axis_tlast_i),
    .q_status_i (q_status),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  scl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_status)
  );

  scl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .token_kind_o  (kind),
    .word_byte_o   (word_byte),
    .token_start_o (token_start),
    .last_o        (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {7'b0, token_start, word_byte};
  assign m_axis_tuser_o = kind;

  // an accepted end of line always leaves work queued
  `SCL_ASSERT_NEXT(a_eol_queued, clk_i, rst_ni,
                   s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i, q_status.not_empty)
  // only the end-of-line result carries tlast
  `SCL_ASSERT_SAME(a_last_is_eol, clk_i, rst_ni,
                   m_axis_tvalid_o && m_axis_tlast_o, kind == KindEol)
  // operators and end of line carry a zero byte
  `SCL_ASSERT_SAME(a_op_zero_byte, clk_i, rst_ni,
                   m_axis_tvalid_o && (kind != KindWord), word_byte == 8'h00)

endmodule
